>>> hdl/scg_pkg.sv
// ============================================================================
// scg_pkg
// Shared widths, constants, register indexes and pipeline sideband types for
// the Steinberg-Cochran-Guinan shear modulus pipeline.
// ============================================================================
`default_nettype none

package scg_pkg;

  // Field and register width
  localparam int unsigned DataW  = 32;
  // APB address width: three registers at 0x0, 0x4, 0x8
  localparam int unsigned AddrW  = 4;
  // Density ratio, Q32.30
  localparam int unsigned RatioW = 62;
  // Cube root of the ratio, Q.10
  localparam int unsigned EtaW   = 21;
  // |A * -p| >> 6
  localparam int unsigned MagW   = 57;
  // Temperature term, signed Q.28
  localparam int unsigned T2W    = 49;
  // Positive softening factor s, Q.28
  localparam int unsigned SW     = 58;

  localparam logic [DataW-1:0] RoomTempQ16 = 32'd19660800;
  localparam logic [SW+1:0]    FracOneQ28  = 60'd268435456;
  localparam logic [DataW-1:0] MinCode     = 32'd1;
  localparam logic [DataW-1:0] MaxCode     = 32'hFFFF_FFFF;

  // Register indexes (word address)
  typedef enum logic [1:0] {
    REG_MU_ZERO          = 2'd0,
    REG_PRESSURE_COEF    = 2'd1,
    REG_TEMPERATURE_COEF = 2'd2
  } reg_idx_t;

  // Sideband carried through the ratio divider and the cube root
  typedef struct packed {
    logic                   bad;
    logic                   sgn;
    logic [MagW-1:0]        mag;
    logic signed [T2W-1:0]  t2;
  } front_side_t;

  // Sideband carried through the pressure-term divider
  typedef struct packed {
    logic                   bad;
    logic                   sgn;
    logic signed [T2W-1:0]  t2;
  } tail_side_t;

endpackage

`default_nettype wire

>>> hdl/scg_in_if.sv
// ============================================================================
// scg_in_if
// Input item channel: one material point per item, valid/ready handshake.
// ============================================================================
`default_nettype none

interface scg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] temp_kelvin;
  logic [31:0] current_density;
  logic [31:0] reference_density;
  logic signed [31:0] pressure_gpa;

  modport source (output valid, temp_kelvin, current_density, reference_density,
                  pressure_gpa, input ready);
  modport sink   (input valid, temp_kelvin, current_density, reference_density,
                  pressure_gpa, output ready);
endinterface

`default_nettype wire

>>> hdl/scg_out_if.sv
// ============================================================================
// scg_out_if
// Result item channel: shear modulus and flags, valid/ready handshake.
// ============================================================================
`default_nettype none

interface scg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] shear_modulus;
  logic        bad_density;
  logic        saturated;

  modport source (output valid, shear_modulus, bad_density, saturated, input ready);
  modport sink   (input valid, shear_modulus, bad_density, saturated, output ready);
endinterface

`default_nettype wire

>>> hdl/scg_div_pipe.sv
// ============================================================================
// scg_div_pipe
// Pipelined restoring divider: one quotient bit per stage, NUM_W stages.
// Sideband data travels with each item.
// ============================================================================
`default_nettype none

module scg_div_pipe #(
  parameter int unsigned NUM_W  = 62,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_in,
  input  wire logic [NUM_W-1:0]  num_in,
  input  wire logic [DEN_W-1:0]  den_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   vld_out,
  output logic [NUM_W-1:0]       quo_out,
  output logic [SIDE_W-1:0]      side_out
);

  logic              vld_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  q_r    [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vld_s;
    logic [DEN_W-1:0]  rem_s;
    logic [NUM_W-1:0]  q_s;
    logic [DEN_W-1:0]  den_s;
    logic [SIDE_W-1:0] side_s;
    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W:0]    diff;

    if (k == 0) begin : g_first
      assign vld_s  = vld_in;
      assign rem_s  = '0;
      assign q_s    = num_in;
      assign den_s  = den_in;
      assign side_s = side_in;
    end else begin : g_next
      assign vld_s  = vld_r[k-1];
      assign rem_s  = rem_r[k-1];
      assign q_s    = q_r[k-1];
      assign den_s  = den_r[k-1];
      assign side_s = side_r[k-1];
    end

    // bring down the next dividend bit and try a subtract
    assign trial = {rem_s, q_s[NUM_W-1]};
    assign diff  = trial - {1'b0, den_s};
    assign fits  = trial >= {1'b0, den_s};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q_r[k]    <= {q_s[NUM_W-2:0], fits};
        den_r[k]  <= den_s;
        side_r[k] <= side_s;
      end
    end
  end

  assign vld_out  = vld_r[NUM_W-1];
  assign quo_out  = q_r[NUM_W-1];
  assign side_out = side_r[NUM_W-1];

endmodule

`default_nettype wire

>>> hdl/scg_cbrt_pipe.sv
// ============================================================================
// scg_cbrt_pipe
// Pipelined integer cube root: one root bit per stage. The running square of
// the partial root is kept so each stage needs only adds and a compare.
// ============================================================================
`default_nettype none

module scg_cbrt_pipe #(
  parameter int unsigned X_W    = 62,
  parameter int unsigned SIDE_W = 8,
  parameter int unsigned Y_W    = (X_W + 2) / 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_in,
  input  wire logic [X_W-1:0]    x_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   vld_out,
  output logic [Y_W-1:0]         y_out,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int unsigned SqW = 2 * Y_W;
  localparam int unsigned BW  = SqW + 3;
  localparam int unsigned CW  = (X_W > BW) ? X_W : BW;

  logic              vld_r  [Y_W];
  logic [X_W-1:0]    x_r    [Y_W];
  logic [Y_W-1:0]    y_r    [Y_W];
  logic [SqW-1:0]    sq_r   [Y_W];
  logic [SIDE_W-1:0] side_r [Y_W];

  for (genvar k = 0; k < Y_W; k++) begin : g_stage
    localparam int unsigned Sh = 3 * (Y_W - 1 - k);

    logic              vld_s;
    logic [X_W-1:0]    x_s;
    logic [Y_W-1:0]    y_s;
    logic [SqW-1:0]    sq_s;
    logic [SIDE_W-1:0] side_s;
    logic [Y_W-1:0]    y0;
    logic [SqW-1:0]    sq0;
    logic [BW-1:0]     sum;
    logic [BW-1:0]     b;
    logic [CW-1:0]     bc;
    logic [CW-1:0]     xs;
    logic              fits;

    if (k == 0) begin : g_first
      assign vld_s  = vld_in;
      assign x_s    = x_in;
      assign y_s    = '0;
      assign sq_s   = '0;
      assign side_s = side_in;
    end else begin : g_next
      assign vld_s  = vld_r[k-1];
      assign x_s    = x_r[k-1];
      assign y_s    = y_r[k-1];
      assign sq_s   = sq_r[k-1];
      assign side_s = side_r[k-1];
    end

    // b = 3*y0*(y0+1) + 1 with y0 = 2y, from the kept square
    assign y0   = {y_s[Y_W-2:0], 1'b0};
    assign sq0  = {sq_s[SqW-3:0], 2'b00};
    assign sum  = BW'(sq0) + BW'(y0);
    assign b    = (sum << 1) + sum + BW'(1);
    assign bc   = CW'(b);
    assign xs   = CW'(x_s >> Sh);
    assign fits = xs >= bc;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= fits ? x_s - X_W'(bc << Sh) : x_s;
        y_r[k]    <= {y0[Y_W-1:1], fits};
        sq_r[k]   <= fits ? sq0 + (SqW'(y0) << 1) + SqW'(1) : sq0;
        side_r[k] <= side_s;
      end
    end
  end

  assign vld_out  = vld_r[Y_W-1];
  assign y_out    = y_r[Y_W-1];
  assign side_out = side_r[Y_W-1];

endmodule

`default_nettype wire

>>> hdl/scg_shear_modulus_core.sv
// ============================================================================
// scg_shear_modulus_core
// Steinberg-Cochran-Guinan shear modulus, one material point per item.
// ============================================================================
// Usage:
//   Items enter on in_ch (temperature, current and reference density,
//   pressure) and results leave on out_ch (shear modulus, bad_density,
//   saturated). Both use valid/ready; an item moves when both are high.
//   The APB port writes mu_zero (0x0), pressure_coef (0x4) and
//   temperature_coef (0x8); write them only while no item is in flight.
//   The pipeline has 1 product stage, 62 stages of density-ratio division,
//   21 stages of cube root, 57 stages of pressure-term division, then
//   factor, modulus product and output register.
//   Throughput is one item per clock unless out_ch stalls; every stage
//   holds at most one item. When the receiver holds out_ch.ready low with
//   a result waiting, the whole pipeline freezes and in_ch.ready drops in
//   the same cycle; nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits and the three
//   registers; the pipeline is ready in the first cycle after reset.
// ============================================================================
`default_nettype none

module scg_shear_modulus_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  scg_in_if.sink                         in_ch,
  scg_out_if.source                      out_ch,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [scg_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  import scg_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DataW-1:0] mu_zero_r;
  logic [DataW-1:0] pressure_coef_r;
  logic [DataW-1:0] temperature_coef_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_zero_r          <= '0;
      pressure_coef_r    <= '0;
      temperature_coef_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_MU_ZERO:          mu_zero_r          <= pwdata;
        REG_PRESSURE_COEF:    pressure_coef_r    <= pwdata;
        REG_TEMPERATURE_COEF: temperature_coef_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_MU_ZERO:          prdata = mu_zero_r;
      REG_PRESSURE_COEF:    prdata = pressure_coef_r;
      REG_TEMPERATURE_COEF: prdata = temperature_coef_r;
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: freeze everything while a result waits
  // --------------------------------------------------------------------------
  logic out_vld_r;
  logic en;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // --------------------------------------------------------------------------
  // Stage F: A * (-p) and B * (T - 300 K)
  // --------------------------------------------------------------------------
  logic signed [DataW-1:0] a_s;
  logic signed [DataW-1:0] b_s;
  logic signed [DataW:0]   neg_press;
  logic signed [DataW:0]   temp_diff;
  logic signed [64:0]      prod1_nxt;
  logic signed [64:0]      prod2_nxt;

  logic                    f_vld_r;
  logic signed [64:0]      f_prod1_r;
  logic signed [64:0]      f_prod2_r;
  logic [DataW-1:0]        f_cur_r;
  logic [DataW-1:0]        f_ref_r;
  logic                    f_bad_r;

  assign a_s       = $signed(pressure_coef_r);
  assign b_s       = $signed(temperature_coef_r);
  assign neg_press = -$signed({in_ch.pressure_gpa[DataW-1], in_ch.pressure_gpa});
  assign temp_diff = $signed({1'b0, in_ch.temp_kelvin}) - $signed({1'b0, RoomTempQ16});
  assign prod1_nxt = a_s * neg_press;
  assign prod2_nxt = b_s * temp_diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_prod1_r <= prod1_nxt;
      f_prod2_r <= prod2_nxt;
      f_cur_r   <= in_ch.current_density;
      f_ref_r   <= in_ch.reference_density;
      f_bad_r   <= (in_ch.current_density == '0) || (in_ch.reference_density == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Sideband for the ratio divider: |A*-p| / 64 and truncated B term
  // --------------------------------------------------------------------------
  logic [64:0]        abs1;
  logic signed [64:0] adj2;
  front_side_t        fside;

  assign abs1 = f_prod1_r[64] ? 65'(-f_prod1_r) : f_prod1_r;
  // round toward zero before the arithmetic shift by 16
  assign adj2 = f_prod2_r + (f_prod2_r[64] ? 65'sd65535 : 65'sd0);

  assign fside.bad = f_bad_r;
  assign fside.sgn = f_prod1_r[64];
  assign fside.mag = abs1[62:6];
  assign fside.t2  = adj2[64:16];

  // --------------------------------------------------------------------------
  // Density ratio, Q32.30
  // --------------------------------------------------------------------------
  logic                       ra_vld;
  logic [RatioW-1:0]          ra_quo;
  logic [$bits(front_side_t)-1:0] ra_side;

  scg_div_pipe #(
    .NUM_W  (RatioW),
    .DEN_W  (DataW),
    .SIDE_W ($bits(front_side_t))
  ) u_ratio_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (f_vld_r),
    .num_in   ({f_cur_r, 30'b0}),
    .den_in   (f_ref_r),
    .side_in  (fside),
    .vld_out  (ra_vld),
    .quo_out  (ra_quo),
    .side_out (ra_side)
  );

  // --------------------------------------------------------------------------
  // eta = cube root of the ratio, Q.10
  // --------------------------------------------------------------------------
  logic                           cb_vld;
  logic [EtaW-1:0]                cb_y;
  logic [$bits(front_side_t)-1:0] cb_side;
  front_side_t                    cside;
  tail_side_t                     tside;
  logic [EtaW-1:0]                eta;

  scg_cbrt_pipe #(
    .X_W    (RatioW),
    .SIDE_W ($bits(front_side_t)),
    .Y_W    (EtaW)
  ) u_cbrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (ra_vld),
    .x_in     (ra_quo),
    .side_in  (ra_side),
    .vld_out  (cb_vld),
    .y_out    (cb_y),
    .side_out (cb_side)
  );

  assign cside     = front_side_t'(cb_side);
  // a ratio below one LSB of eta is taken as one LSB
  assign eta       = (cb_y == '0) ? EtaW'(1) : cb_y;
  assign tside.bad = cside.bad;
  assign tside.sgn = cside.sgn;
  assign tside.t2  = cside.t2;

  // --------------------------------------------------------------------------
  // Pressure term magnitude: (|A*-p| / 64) / eta
  // --------------------------------------------------------------------------
  logic                          pd_vld;
  logic [MagW-1:0]               pd_quo;
  logic [$bits(tail_side_t)-1:0] pd_side;
  tail_side_t                    pside;

  scg_div_pipe #(
    .NUM_W  (MagW),
    .DEN_W  (EtaW),
    .SIDE_W ($bits(tail_side_t))
  ) u_press_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (cb_vld),
    .num_in   (cside.mag),
    .den_in   (eta),
    .side_in  (tside),
    .vld_out  (pd_vld),
    .quo_out  (pd_quo),
    .side_out (pd_side)
  );

  assign pside = tail_side_t'(pd_side);

  // --------------------------------------------------------------------------
  // Stage S: s = 1 + t1 - t2, Q.28
  // --------------------------------------------------------------------------
  logic signed [MagW:0] t1;
  logic signed [SW+1:0] s_full;
  logic                 s_vld_r;
  logic                 s_pos_r;
  logic                 s_bad_r;
  logic [SW-1:0]        s_us_r;

  assign t1     = pside.sgn ? -$signed({1'b0, pd_quo}) : $signed({1'b0, pd_quo});
  assign s_full = $signed(FracOneQ28) + (SW+2)'(t1) - (SW+2)'(pside.t2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (en) begin
      s_vld_r <= pd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_pos_r <= !s_full[SW+1] && (s_full != '0);
      s_bad_r <= pside.bad;
      s_us_r  <= s_full[SW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage M: mu_zero * s as two partial products
  // --------------------------------------------------------------------------
  localparam int unsigned LoW = 29;
  localparam int unsigned PW  = DataW + LoW;

  logic          m_vld_r;
  logic          m_pos_r;
  logic          m_bad_r;
  logic [PW-1:0] m_lo_r;
  logic [PW-1:0] m_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_pos_r <= s_pos_r && (mu_zero_r != '0);
      m_bad_r <= s_bad_r;
      m_lo_r  <= PW'(mu_zero_r) * PW'(s_us_r[LoW-1:0]);
      m_hi_r  <= PW'(mu_zero_r) * PW'(s_us_r[SW-1:LoW]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: sum, shift by 28, clamp, output register
  // --------------------------------------------------------------------------
  localparam int unsigned FW = PW + LoW;

  logic [FW-1:0]    prod;
  logic             ovf;
  logic [DataW-1:0] r_mu;
  logic [DataW-1:0] mu_nxt;
  logic             sat_nxt;
  logic [DataW-1:0] out_mu_r;
  logic             out_bad_r;
  logic             out_sat_r;

  assign prod = {m_hi_r, {LoW{1'b0}}} + FW'(m_lo_r);
  assign ovf  = |prod[FW-1:DataW+28];
  assign r_mu = prod[DataW+27:28];

  always_comb begin
    mu_nxt  = MinCode;
    sat_nxt = 1'b0;
    if (!m_bad_r && m_pos_r) begin
      if (ovf) begin
        mu_nxt  = MaxCode;
        sat_nxt = 1'b1;
      end else if (r_mu != '0) begin
        mu_nxt = r_mu;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mu_r  <= mu_nxt;
      out_bad_r <= m_bad_r;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.shear_modulus = out_mu_r;
  assign out_ch.bad_density   = out_bad_r;
  assign out_ch.saturated     = out_sat_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_mu_r != '0))
    else $error("result below the floor");

  a_bad_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_bad_r) |-> (out_mu_r == MinCode && !out_sat_r))
    else $error("bad density item not returned at the floor");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_sat_r) |-> (out_mu_r == MaxCode))
    else $error("saturated flag without maximum code");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> ($stable(m_vld_r) && $stable(s_vld_r)))
    else $error("pipeline moved while the result was stalled");

endmodule

`default_nettype wire

>>> tb/sv/scg_modulus_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// scg_modulus_checker
// Watches the item channels and the APB port of the shear modulus core,
// predicts each result from the accepted items and the written registers,
// and compares every field of every result in order.
// ============================================================================

module scg_modulus_checker (
  input  logic        clk,
  input  logic        rst_n,
  scg_in_if           in_ch,
  scg_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [scg_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);
  import scg_pkg::*;

  typedef struct {
    logic [31:0] modulus;
    logic        bad;
    logic        sat;
  } modulus_t;

  // Shadow copy of the register file
  logic [31:0]        mu_zero_q;
  logic signed [31:0] a_coef_q;
  logic signed [31:0] b_coef_q;

  modulus_t expected_q[$];

  assign pending = expected_q.size();

  // Exact integer cube root, one result bit per step
  function automatic logic [63:0] int_cube_root(logic [63:0] x);
    logic [63:0] y;
    logic [63:0] bb;
    int sh;
    y = 0;
    for (sh = 63; sh >= 0; sh -= 3) begin
      y = y << 1;
      bb = 3 * y * (y + 1) + 1;
      if ((x >> sh) >= bb) begin
        x = x - (bb << sh);
        y = y + 1;
      end
    end
    return y;
  endfunction

  function automatic modulus_t predict_modulus(logic [31:0] temp, logic [31:0] cur,
                                               logic [31:0] dens0, logic signed [31:0] press);
    modulus_t r;
    logic [63:0] ratio;
    logic [63:0] eta;
    longint a, b, p, tk, t1, t2, s, div;
    logic [95:0] scaled;
    r.modulus = MinCode;
    r.bad = 1'b0;
    r.sat = 1'b0;
    if (cur == 0 || dens0 == 0) begin
      r.bad = 1'b1;
      return r;
    end
    ratio = ({32'b0, cur} << 30) / {32'b0, dens0};
    eta = int_cube_root(ratio);
    if (eta == 0) eta = 1;
    a = a_coef_q;
    b = b_coef_q;
    p = press;
    tk = {32'b0, temp};
    div = longint'(eta * 64);
    t1 = (a * (-p)) / div;
    t2 = (b * (tk - longint'({32'b0, RoomTempQ16}))) / 64'sd65536;
    s = longint'(FracOneQ28) + t1 - t2;
    if (s > 0 && mu_zero_q != 0) begin
      scaled = (96'(mu_zero_q) * 96'(s)) >> 28;
      if (scaled > 96'(MaxCode)) begin
        r.modulus = MaxCode;
        r.sat = 1'b1;
      end else if (scaled != 0) begin
        r.modulus = scaled[31:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    modulus_t e;
    int nerr;
    if (!rst_n) begin
      mu_zero_q <= '0;
      a_coef_q  <= '0;
      b_coef_q  <= '0;
      errors    <= 0;
      expected_q.delete();
    end else begin
      nerr = 0;
      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[AddrW-1:2]))
          REG_MU_ZERO:          mu_zero_q <= pwdata;
          REG_PRESSURE_COEF:    a_coef_q  <= pwdata;
          REG_TEMPERATURE_COEF: b_coef_q  <= pwdata;
          default: ;
        endcase
      end
      // Accepted input item
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(predict_modulus(in_ch.temp_kelvin, in_ch.current_density,
                                             in_ch.reference_density, in_ch.pressure_gpa));
      // Accepted result item
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no item pending: modulus %h", out_ch.shear_modulus);
          nerr = nerr + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.shear_modulus !== e.modulus) begin
            $error("shear_modulus expected %h actual %h", e.modulus, out_ch.shear_modulus);
            nerr = nerr + 1;
          end
          if (out_ch.bad_density !== e.bad) begin
            $error("bad_density expected %b actual %b", e.bad, out_ch.bad_density);
            nerr = nerr + 1;
          end
          if (out_ch.saturated !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, out_ch.saturated);
            nerr = nerr + 1;
          end
        end
      end
      errors <= errors + nerr;
    end
  end

endmodule

>>> tb/sv/scg_shear_modulus_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// scg_shear_modulus_core_test
// Drives material points and register settings into the shear modulus core,
// with random idling on both channels, a long receiver stall and a full
// drain; the checker beside the block predicts and compares every result.
// ============================================================================

module scg_shear_modulus_core_test;
  import scg_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int PhaseItems = 200;
  localparam int NumPhases  = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;
  int cycles = 0;
  logic quiet = 1'b0;       // no idling in the last part of the run
  logic hold_rx = 1'b0;     // asks the receiver for one long stall

  scg_in_if  in_ch ();
  scg_out_if out_ch ();

  scg_shear_modulus_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  scg_modulus_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold on request
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ch.ready <= 1'b1;
        hold_rx = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Setup phase, then access phase; the caller ends the transfer
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_coefs(logic [31:0] mu0, logic [31:0] a, logic [31:0] b);
    reg_write(REG_MU_ZERO, mu0);
    reg_write(REG_PRESSURE_COEF, a);
    reg_write(REG_TEMPERATURE_COEF, b);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item and hold it until accepted; a random gap may follow unless quiet is set
  task automatic send_point(logic [31:0] temp, logic [31:0] cur, logic [31:0] dens0,
                            logic [31:0] press);
    logic ok;
    in_ch.valid <= 1'b1;
    in_ch.temp_kelvin <= temp;
    in_ch.current_density <= cur;
    in_ch.reference_density <= dens0;
    in_ch.pressure_gpa <= press;
    do begin
      @(negedge clk);
      ok = in_ch.ready;
      @(posedge clk);
    end while (!ok);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_temp();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
      default: return RoomTempQ16 + $urandom_range(0, 32'h0800_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_density();
    case ($urandom_range(0, 11))
      0: return 32'd0;
      1: return $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
      2, 3: return $urandom();
      default: return $urandom_range(32'h0100_0000, 32'h2000_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_press();
    case ($urandom_range(0, 4))
      0, 1: return $urandom();
      default: return $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
    endcase
  endfunction

  initial begin
    logic [31:0] d;
    in_ch.valid = 1'b0;
    in_ch.temp_kelvin = '0;
    in_ch.current_density = '0;
    in_ch.reference_density = '0;
    in_ch.pressure_gpa = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: realistic metal-like coefficients, then corner points
    set_coefs(32'd76 << 16, 32'd3_200_000, 32'd80_530);
    d = 32'd7800 << 16;
    send_point(RoomTempQ16, d, d, 32'd0);
    send_point(32'd0, d, d, 32'd0);
    send_point(32'hFFFF_FFFF, d, d, 32'd0);
    send_point(RoomTempQ16, 32'd0, d, 32'd0);
    send_point(RoomTempQ16, d, 32'd0, 32'd0);
    send_point(RoomTempQ16, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_point(RoomTempQ16, 32'd1, 32'hFFFF_FFFF, 32'd0);       // ratio below one LSB
    send_point(RoomTempQ16, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000);
    send_point(RoomTempQ16, d, d, 32'h8000_0000);               // huge compression
    send_point(RoomTempQ16, d, d, 32'h7FFF_FFFF);               // factor goes negative
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'd0, 32'd1, 32'd1, 32'h8000_0000);
    send_point(RoomTempQ16, d, d, 32'hFFF0_0000);
    send_point(32'h0100_0000, 32'd8000 << 16, d, 32'h0010_0000);
    drain();

    // Random phases, extreme settings among them
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_coefs(32'd0, $urandom(), $urandom());
        1: set_coefs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        2: set_coefs(32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        3: set_coefs(32'hFFFF_FFFF, 32'd0, 32'd0);
        default: set_coefs($urandom_range(0, 1) ? $urandom() : 32'd46 << 16,
                           $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0100_0000),
                           $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0004_0000));
      endcase
      if (ph == NumPhases - 1) quiet = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 2 && i == 20) hold_rx = 1'b1;
        if (ph == 4 && i == PhaseItems / 2) drain();
        send_point(rand_temp(), rand_density(), rand_density(), rand_press());
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/scg_pkg.sv
hdl/scg_in_if.sv
hdl/scg_out_if.sv
hdl/scg_div_pipe.sv
hdl/scg_cbrt_pipe.sv
hdl/scg_shear_modulus_core.sv
tb/sv/scg_modulus_checker.sv
tb/sv/scg_shear_modulus_core_test.sv
